// ===== src/rle_pkg.sv =====
`default_nettype none

package rle_pkg;

    // default number of decimal digits in the run counter
    localparam int COUNT_DIGITS_DEF = 5;

    // depth of the command queue between front and back
    localparam int CMD_DEPTH = 2;

    // ASCII code of the digit zero
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // framing flags carried with each run command
    typedef struct packed {
        logic is_last;   // run byte is the last word caused by its input
        logic is_end;    // run byte closes the whole encoded string
    } t_cmd_flags;

    // front status seen by the top level
    typedef struct packed {
        logic run_open;  // a run is in progress
        logic pend;      // a second run command waits for the queue
    } t_front_stat;

endpackage

`default_nettype wire

// ===== src/rle_fifo.sv =====
`default_nettype none

module rle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    // advance pointers and fill count
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (wr) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // store the incoming word
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/rle_front.sv =====
`default_nettype none

module rle_front #(
    parameter int COUNT_DIGITS = rle_pkg::COUNT_DIGITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic [7:0]           i_in_char,
    input  wire logic                 i_in_last,
    output logic                      o_full,
    input  wire logic                 i_q_full,
    output logic                      o_q_push,
    output logic [4*COUNT_DIGITS+9:0] o_q_data,
    output rle_pkg::t_front_stat      o_stat
);

    localparam int CW    = 4 * COUNT_DIGITS;
    localparam int CMD_W = CW + 8 + $bits(rle_pkg::t_cmd_flags);

    logic [7:0]       r_byte, n_byte;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_open, n_open;
    logic             r_pend, n_pend;
    logic [CMD_W-1:0] r_pcmd, n_pcmd;
    logic [CW-1:0]    cnt_inc;
    logic             cnt_full;
    logic             carry;
    logic             accept;
    rle_pkg::t_cmd_flags flg_close, flg_final;

    assign o_full = r_pend || i_q_full;
    assign accept = i_push && !o_full;
    assign o_stat = '{run_open: r_open, pend: r_pend};

    assign flg_close = '{is_last: !i_in_last, is_end: 1'b0};
    assign flg_final = '{is_last: 1'b1, is_end: 1'b1};

    // increment the BCD counter, carry ripples through the nines
    always_comb begin
        carry = 1'b1;
        for (int d = 0; d < COUNT_DIGITS; d++) begin
            if (carry) begin
                cnt_inc[4*d +: 4] = (r_cnt[4*d +: 4] == 4'd9) ? 4'd0
                                                              : r_cnt[4*d +: 4] + 4'd1;
            end else begin
                cnt_inc[4*d +: 4] = r_cnt[4*d +: 4];
            end
            carry = carry && (r_cnt[4*d +: 4] == 4'd9);
        end
        cnt_full = carry;
    end

    // classify the byte and issue run commands
    always_comb begin
        n_byte   = r_byte;
        n_cnt    = r_cnt;
        n_open   = r_open;
        n_pend   = r_pend;
        n_pcmd   = r_pcmd;
        o_q_push = 1'b0;
        o_q_data = r_pcmd;
        if (r_pend) begin
            if (!i_q_full) begin
                o_q_push = 1'b1;
                n_pend   = 1'b0;
            end
        end else if (accept) begin
            if (!r_open) begin
                if (i_in_last) begin
                    o_q_push = 1'b1;
                    o_q_data = {CW'(1), i_in_char, flg_final};
                end else begin
                    n_open = 1'b1;
                    n_byte = i_in_char;
                    n_cnt  = CW'(1);
                end
            end else if (i_in_char == r_byte && !cnt_full) begin
                if (i_in_last) begin
                    o_q_push = 1'b1;
                    o_q_data = {cnt_inc, r_byte, flg_final};
                    n_open   = 1'b0;
                    n_byte   = '0;
                    n_cnt    = '0;
                end else begin
                    n_cnt = cnt_inc;
                end
            end else begin
                // close the open run, start a new one with this byte
                o_q_push = 1'b1;
                o_q_data = {r_cnt, r_byte, flg_close};
                if (i_in_last) begin
                    n_pend = 1'b1;
                    n_pcmd = {CW'(1), i_in_char, flg_final};
                    n_open = 1'b0;
                    n_byte = '0;
                    n_cnt  = '0;
                end else begin
                    n_byte = i_in_char;
                    n_cnt  = CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
            r_cnt  <= '0;
            r_open <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_byte <= n_byte;
            r_cnt  <= n_cnt;
            r_open <= n_open;
            r_pend <= n_pend;
        end
    end

    // hold the second command of a closing input
    always_ff @(posedge i_clk) begin
        r_pcmd <= n_pcmd;
    end

endmodule

`default_nettype wire

// ===== src/rle_back.sv =====
`default_nettype none

module rle_back #(
    parameter int COUNT_DIGITS = rle_pkg::COUNT_DIGITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_empty,
    input  wire logic [4*COUNT_DIGITS+9:0] i_q_data,
    output logic                      o_q_pop,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output logic [7:0]                o_out_char,
    output logic                      o_out_last,
    output logic                      o_out_end
);

    localparam int CW = 4 * COUNT_DIGITS;
    localparam int IW = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
    localparam int FW = $bits(rle_pkg::t_cmd_flags);
    localparam int CMD_HI = CW + 8 + FW - 1;

    logic [CW-1:0]       r_cnt, n_cnt;
    logic [7:0]          r_byte, n_byte;
    rle_pkg::t_cmd_flags r_flags, n_flags;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_bph, n_bph;
    logic                r_act, n_act;
    logic [7:0]          r_ochar, n_ochar;
    logic                r_olast, n_olast;
    logic                r_oend, n_oend;
    logic                r_oval, n_oval;
    logic [CW-1:0]       q_cnt;
    logic [IW-1:0]       lead;
    logic [3:0]          dig;
    logic                slot_free, step, fin;

    assign q_cnt     = i_q_data[CMD_HI -: CW];
    assign slot_free = !r_oval || i_pop;
    assign step      = r_act && slot_free;
    assign fin       = step && r_bph;
    assign o_q_pop   = !i_q_empty && (!r_act || fin);
    assign dig       = r_cnt[{r_idx, 2'b00} +: 4];

    assign o_empty    = !r_oval;
    assign o_out_char = r_ochar;
    assign o_out_last = r_olast;
    assign o_out_end  = r_oend;

    // find the most significant nonzero digit of the new run
    always_comb begin
        lead = '0;
        for (int d = 0; d < COUNT_DIGITS; d++) begin
            if (q_cnt[4*d +: 4] != 4'd0) begin
                lead = IW'(d);
            end
        end
    end

    // walk digits then the run byte, one word per cycle while the output slot is free
    always_comb begin
        n_cnt   = r_cnt;
        n_byte  = r_byte;
        n_flags = r_flags;
        n_idx   = r_idx;
        n_bph   = r_bph;
        n_act   = r_act;
        n_ochar = r_ochar;
        n_olast = r_olast;
        n_oend  = r_oend;
        n_oval  = r_oval;
        if (i_pop) begin
            n_oval = 1'b0;
        end
        if (step) begin
            n_oval = 1'b1;
            if (r_bph) begin
                n_ochar = r_byte;
                n_olast = r_flags.is_last;
                n_oend  = r_flags.is_end;
                n_act   = 1'b0;
            end else begin
                n_ochar = rle_pkg::ASCII_ZERO + {4'b0000, dig};
                n_olast = 1'b0;
                n_oend  = 1'b0;
                if (r_idx == '0) begin
                    n_bph = 1'b1;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
        end
        if (o_q_pop) begin
            n_cnt   = q_cnt;
            n_byte  = i_q_data[FW +: 8];
            n_flags = i_q_data[FW-1:0];
            n_idx   = lead;
            n_bph   = 1'b0;
            n_act   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_oval <= 1'b0;
            r_bph  <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_act  <= n_act;
            r_oval <= n_oval;
            r_bph  <= n_bph;
            r_idx  <= n_idx;
        end
    end

    // hold run payload and output word
    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_byte  <= n_byte;
        r_flags <= n_flags;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
        r_oend  <= n_oend;
    end

endmodule

`default_nettype wire

// ===== src/rle_text_encoder.sv =====
// Run-length text encoder: each run becomes its decimal length and then the run byte.
// A run passes through the command queue and the back's run registers to the output
// register. The front takes one byte per cycle while the queue has room and no second
// command waits; the back writes one word per cycle while the receiver pops, digits
// plus one per run. Synchronous active-low reset clears run state, queue and output.
`default_nettype none

module rle_text_encoder #(
    parameter int COUNT_DIGITS = rle_pkg::COUNT_DIGITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_in_last,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_out_char,
    output logic            o_out_last,
    output logic            o_out_end
);

    localparam int CMD_W = 4 * COUNT_DIGITS + 8 + $bits(rle_pkg::t_cmd_flags);

    logic                 q_push, q_full, q_pop, q_empty;
    logic [CMD_W-1:0]     q_wdata, q_rdata;
    rle_pkg::t_front_stat front_stat;

    // accept and classify bytes
    rle_front #(
        .COUNT_DIGITS(COUNT_DIGITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_in_char (i_in_char),
        .i_in_last (i_in_last),
        .o_full    (o_full),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata),
        .o_stat    (front_stat)
    );

    // queue run commands
    rle_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(rle_pkg::CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // serialize digits and run bytes
    rle_back #(
        .COUNT_DIGITS(COUNT_DIGITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_rdata),
        .o_q_pop    (q_pop),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_out_char (o_out_char),
        .o_out_last (o_out_last),
        .o_out_end  (o_out_end)
    );

    // front never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    // back never reads an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command queue underflow");

    // a final byte closes the run
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && i_in_last) |=> !front_stat.run_open)
        else $error("run left open after final byte");

    // a waiting second command holds off the input
    a_pend_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_stat.pend |-> o_full)
        else $error("input accepted while a command waits");

    // end of string is always the last word of its byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out_end) |-> o_out_last)
        else $error("end word without last flag");

endmodule

`default_nettype wire

// ===== bench/rle_text_encoder_tb.sv =====
`timescale 1ns / 100ps

module rle_text_encoder_tb;

    localparam int N_DIG = rle_pkg::COUNT_DIGITS_DEF;
    localparam int CNT_W = 4 * N_DIG;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 60;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 20;

    // one encoded output word
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       is_end;
    } t_enc_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_push;
    logic       o_full;
    logic [7:0] i_in_char;
    logic       i_in_last;
    logic       o_empty;
    logic       i_pop = 1'b0;
    logic [7:0] o_out_char;
    logic       o_out_last;
    logic       o_out_end;

    // encoder state mirrored by the predictor
    logic [7:0]       run_chr;
    logic [CNT_W-1:0] run_len;
    bit               run_active;

    t_enc_word word_q[$];
    t_enc_word exp_word;
    int        err_cnt = 0;
    int        cycle_cnt = 0;
    int        rx_hold_cnt = 0;
    int        rx_stall = 0;
    bit        idle_on = 1'b1;

    rle_text_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_in_char  (i_in_char),
        .i_in_last  (i_in_last),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_out_char (o_out_char),
        .o_out_last (o_out_last),
        .o_out_end  (o_out_end)
    );

    always #5 i_clk = ~i_clk;

    // abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit count_at_max(input logic [CNT_W-1:0] v);
        for (int d = 0; d < N_DIG; d++)
            if (v[4*d +: 4] != 4'd9) return 1'b0;
        return 1'b1;
    endfunction

    // decimal increment with carry across digits
    function automatic logic [CNT_W-1:0] count_plus_one(input logic [CNT_W-1:0] v);
        for (int d = 0; d < N_DIG; d++) begin
            if (v[4*d +: 4] < 4'd9) begin
                v[4*d +: 4] = v[4*d +: 4] + 4'd1;
                return v;
            end
            v[4*d +: 4] = 4'd0;
        end
        return v;
    endfunction

    // queue the open run: digits without leading zeros, then the byte
    task automatic queue_run();
        bit        started;
        logic [3:0] dig;
        t_enc_word w;
        started = 1'b0;
        for (int d = N_DIG - 1; d >= 0; d--) begin
            dig = run_len[4*d +: 4];
            if (dig != 4'd0 || started || d == 0) begin
                started = 1'b1;
                w = '{ch: rle_pkg::ASCII_ZERO + {4'd0, dig}, last: 1'b0, is_end: 1'b0};
                word_q.push_back(w);
            end
        end
        w = '{ch: run_chr, last: 1'b0, is_end: 1'b0};
        word_q.push_back(w);
    endtask

    // work out the words caused by one input byte
    task automatic predict_byte(input logic [7:0] c, input logic l);
        int        first;
        t_enc_word w;
        first = word_q.size();
        if (!run_active) begin
            run_chr    = c;
            run_len    = CNT_W'(1);
            run_active = 1'b1;
        end else if (c == run_chr && !count_at_max(run_len)) begin
            run_len = count_plus_one(run_len);
        end else begin
            queue_run();
            run_chr = c;
            run_len = CNT_W'(1);
        end
        if (l) begin
            queue_run();
            run_chr    = 8'd0;
            run_len    = '0;
            run_active = 1'b0;
        end
        if (word_q.size() > first) begin
            w = word_q.pop_back();
            w.last   = 1'b1;
            w.is_end = l;
            word_q.push_back(w);
        end
    endtask

    // offer one byte and hold it until the block takes it
    task automatic send_byte(input logic [7:0] c, input logic l);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predict_byte(c, l);
        i_push    <= 1'b1;
        i_in_char <= c;
        i_in_last <= l;
        do @(posedge i_clk); while (o_full);
    endtask

    // stop offering and wait for every expected word
    task automatic wait_drained();
        i_push <= 1'b0;
        while (word_q.size() != 0) @(posedge i_clk);
    endtask

    // check each accepted word, then decide the next pop
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (word_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("unexpected word: char=%h last=%b end=%b",
                             o_out_char, o_out_last, o_out_end);
            end else begin
                exp_word = word_q.pop_front();
                if (o_out_char !== exp_word.ch || o_out_last !== exp_word.last ||
                    o_out_end !== exp_word.is_end) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 exp_word.ch, exp_word.last, exp_word.is_end,
                                 o_out_char, o_out_last, o_out_end);
                end
            end
        end
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            i_pop <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
        end
    end

    // single-byte strings, including the byte extremes
    task automatic test_single_bytes();
        send_byte(8'h41, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    // short runs, zero byte as data, end on a new byte
    task automatic test_short_runs();
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    // two-digit count, last byte extends the run
    task automatic test_count_digits();
        for (int k = 0; k < 10; k++) send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b1);
        wait_drained();
    endtask

    // hold the receiver off while distinct bytes keep coming
    task automatic test_back_pressure();
        rx_hold_cnt = 400;
        for (int k = 0; k < 30; k++) send_byte(8'(k * 37 + 1), k == 29);
        wait_drained();
    endtask

    // random strings built from runs, some bursts without idling
    task automatic test_random_strings();
        int         sent;
        int         n_runs;
        int         len;
        logic [7:0] c;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            n_runs = $urandom_range(1, 6);
            for (int r = 0; r < n_runs; r++) begin
                if ($urandom_range(0, 2) == 0)
                    c = 8'($urandom_range(0, 255));
                else
                    c = 8'h61 + 8'($urandom_range(0, 3));
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12)
                                                  : $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    send_byte(c, (r == n_runs - 1) && (k == len - 1));
                    sent++;
                end
            end
            if ($urandom_range(0, 4) == 0) wait_drained();
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_push     <= 1'b0;
        i_in_char  <= 8'd0;
        i_in_last  <= 1'b0;
        run_chr    = 8'd0;
        run_len    = '0;
        run_active = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_bytes();
        test_short_runs();
        test_count_digits();
        test_back_pressure();
        test_random_strings();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && word_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== rle_text_encoder.f =====
src/rle_pkg.sv
src/rle_fifo.sv
src/rle_front.sv
src/rle_back.sv
src/rle_text_encoder.sv
bench/rle_text_encoder_tb.sv
